FILE: hdl/nsp_pkg.sv
// nsp_pkg: shared types, codes and helpers for the NMEA sentence parser.
// Used by nsp_step, nmea_sentence_parser and nsp_checker. No dependencies.

package nsp_pkg;

  // Sizing
  localparam int MAX_COMMAND_LEN = 8;   // 1..32
  localparam int MAX_DATA_LEN    = 128; // 8..128

  // Parse phases
  localparam logic [2:0] PH_SEARCH = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_DATA   = 3'd2;
  localparam logic [2:0] PH_HEX1   = 3'd3;
  localparam logic [2:0] PH_HEX2   = 3'd4;

  // Event codes
  localparam logic [2:0] EV_CMD_BYTE  = 3'd0;
  localparam logic [2:0] EV_CMD_END   = 3'd1;
  localparam logic [2:0] EV_DATA_BYTE = 3'd2;
  localparam logic [2:0] EV_CK_OK     = 3'd3;
  localparam logic [2:0] EV_NO_CK     = 3'd4;
  localparam logic [2:0] EV_CK_BAD    = 3'd5;
  localparam logic [2:0] EV_OVERFLOW  = 3'd6;

  // Characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] checksum;
    logic [6:0] position;
    logic [3:0] high_nibble;
  } parse_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [6:0] position;
    logic [7:0] computed;
    logic [7:0] received;
  } event_t;

  typedef struct packed {
    parse_state_t state_next;
    logic         emit;
    event_t       evt;
  } step_t;

  // Hex digit to nibble, case-insensitive; non-hex characters still map to a nibble by the rule below.
  // '0'..'9' -> c - 0x30, otherwise c - 0x41 + 10, both mod 16.
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      v = c - 8'd32;
    end
    if (v <= CH_NINE) begin
      hex_nibble = v[3:0];
    end else begin
      hex_nibble = v[3:0] + 4'd9;
    end
  endfunction

endpackage

FILE: hdl/nsp_step.sv
// nsp_step: next-state and event logic for one received byte.
// Depends on nsp_pkg.

module nsp_step (
  input  nsp_pkg::parse_state_t state,
  input  logic [7:0]            rx_byte,
  output nsp_pkg::step_t        step
);

  logic [7:0] cs_xor;
  logic [7:0] pos_inc;
  logic [7:0] received_full;

  assign cs_xor        = state.checksum ^ rx_byte;
  assign pos_inc       = {1'b0, state.position} + 8'd1;
  assign received_full = {state.high_nibble, nsp_pkg::hex_nibble(rx_byte)};

  always_comb begin
    step.state_next    = state;
    step.emit          = 1'b0;
    step.evt.kind      = nsp_pkg::EV_CMD_BYTE;
    step.evt.value     = rx_byte;
    step.evt.position  = state.position;
    step.evt.computed  = state.checksum;
    step.evt.received  = 8'd0;

    case (state.phase)
      nsp_pkg::PH_CMD: begin
        step.emit = 1'b1;
        if (rx_byte == nsp_pkg::CH_STAR) begin
          // star ends the command and is not part of the checksum
          step.state_next.position = 7'd0;
          step.state_next.phase    = nsp_pkg::PH_HEX1;
          step.evt.kind            = nsp_pkg::EV_CMD_END;
        end else begin
          step.state_next.checksum = cs_xor;
          step.evt.computed        = cs_xor;
          if (rx_byte == nsp_pkg::CH_SPACE || rx_byte == nsp_pkg::CH_COMMA) begin
            step.state_next.position = 7'd0;
            step.state_next.phase    = nsp_pkg::PH_DATA;
            step.evt.kind            = nsp_pkg::EV_CMD_END;
          end else if (state.position >= 7'(nsp_pkg::MAX_COMMAND_LEN)) begin
            step.state_next.phase = nsp_pkg::PH_SEARCH;
            step.evt.kind         = nsp_pkg::EV_OVERFLOW;
          end else begin
            step.state_next.position = pos_inc[6:0];
            step.evt.kind            = nsp_pkg::EV_CMD_BYTE;
          end
        end
      end

      nsp_pkg::PH_DATA: begin
        if (rx_byte == nsp_pkg::CH_STAR) begin
          step.state_next.phase = nsp_pkg::PH_HEX1;
        end else if (rx_byte == nsp_pkg::CH_NEWLINE) begin
          step.emit             = 1'b1;
          step.state_next.phase = nsp_pkg::PH_SEARCH;
          step.evt.kind         = nsp_pkg::EV_NO_CK;
        end else begin
          step.emit                = 1'b1;
          step.state_next.checksum = cs_xor;
          step.evt.computed        = cs_xor;
          if (pos_inc >= 8'(nsp_pkg::MAX_DATA_LEN)) begin
            step.state_next.phase = nsp_pkg::PH_SEARCH;
            step.evt.kind         = nsp_pkg::EV_OVERFLOW;
          end else begin
            step.state_next.position = pos_inc[6:0];
            step.evt.kind            = nsp_pkg::EV_DATA_BYTE;
          end
        end
      end

      nsp_pkg::PH_HEX1: begin
        step.state_next.high_nibble = nsp_pkg::hex_nibble(rx_byte);
        step.state_next.phase       = nsp_pkg::PH_HEX2;
      end

      nsp_pkg::PH_HEX2: begin
        step.emit             = 1'b1;
        step.state_next.phase = nsp_pkg::PH_SEARCH;
        step.evt.received     = received_full;
        step.evt.kind         = (received_full == state.checksum) ? nsp_pkg::EV_CK_OK
                                                                  : nsp_pkg::EV_CK_BAD;
      end

      default: begin
        // search; unused phase codes land here too
        step.state_next.phase = nsp_pkg::PH_SEARCH;
        if (rx_byte == nsp_pkg::CH_DOLLAR) begin
          step.state_next.checksum = 8'd0;
          step.state_next.position = 7'd0;
          step.state_next.phase    = nsp_pkg::PH_CMD;
        end
      end
    endcase
  end

endmodule

FILE: hdl/nmea_sentence_parser.sv
// nmea_sentence_parser: top level, input register, parse state and event register.
// Depends on nsp_pkg and nsp_step.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------------------
//  rx      | rx_valid    | rx_stall    | rx_byte
//  event   | event_valid | event_stall | event_kind, byte_value, position,
//          |             |             | computed_checksum, received_checksum
//
// One byte per cycle, sustained, while no stall holds the input. A byte lands in the
// input register at its transaction edge and is parsed from there, so its event (if
// any) is loaded into the event register once the byte is allowed to move on.
// Reset (rst, synchronous) empties both registers and returns the parser to
// the search for '$' with checksum, position and nibble at zero.
// A stalled event holds; the input side stalls only when the held byte would
// produce an event and the event register cannot be freed in that cycle.
// Bytes that make no event (search, '*' in data, first hex digit) never stall.

module nmea_sentence_parser (
  input  logic       clk,
  input  logic       rst,

  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,

  output logic       event_valid,
  input  logic       event_stall,
  output logic [2:0] event_kind,
  output logic [7:0] byte_value,
  output logic [6:0] position,
  output logic [7:0] computed_checksum,
  output logic [7:0] received_checksum
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // parser state
  nsp_pkg::parse_state_t state;

  // combinational step result
  nsp_pkg::step_t step;

  // held byte may move on: it emits nothing, or the event slot is free/draining
  logic advance;
  logic load_event;

  nsp_step u_step (
    .state   (state),
    .rx_byte (in_byte),
    .step    (step)
  );

  assign advance    = !step.emit || !event_valid || !event_stall;
  assign load_event = in_valid && advance && step.emit;
  assign rx_stall   = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!rx_stall) begin
      in_valid <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rx_stall && rx_valid) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= nsp_pkg::PH_SEARCH;
      state.checksum    <= 8'd0;
      state.position    <= 7'd0;
      state.high_nibble <= 4'd0;
    end else if (in_valid && advance) begin
      state <= step.state_next;
    end
  end

  // event register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load_event) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_event) begin
      event_kind        <= step.evt.kind;
      byte_value        <= step.evt.value;
      position          <= step.evt.position;
      computed_checksum <= step.evt.computed;
      received_checksum <= step.evt.received;
    end
  end

endmodule

FILE: hdl/nsp_checker.sv
// nsp_checker: port-level assertions for nmea_sentence_parser, with its bind.
// Depends on nsp_pkg and nmea_sentence_parser.

module nsp_checker (
  input logic       clk,
  input logic       rst,
  input logic       event_valid,
  input logic       event_stall,
  input logic [2:0] event_kind,
  input logic [7:0] computed_checksum,
  input logic [7:0] received_checksum
);

  // a stalled event stays
  a_event_hold: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_stall |=> event_valid)
    else $error("event dropped while stalled");

  // decoded checksum only on checksum verdicts
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind != nsp_pkg::EV_CK_OK && event_kind != nsp_pkg::EV_CK_BAD
    |-> received_checksum == 8'd0)
    else $error("received checksum nonzero outside verdict");

  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == nsp_pkg::EV_CK_OK |-> received_checksum == computed_checksum)
    else $error("checksum ok with differing values");

  a_bad_differ: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_kind == nsp_pkg::EV_CK_BAD
    |-> received_checksum != computed_checksum)
    else $error("checksum mismatch with equal values");

endmodule

bind nmea_sentence_parser nsp_checker u_nsp_checker (
  .clk               (clk),
  .rst               (rst),
  .event_valid       (event_valid),
  .event_stall       (event_stall),
  .event_kind        (event_kind),
  .computed_checksum (computed_checksum),
  .received_checksum (received_checksum)
);

FILE: dv/testbench.sv
// testbench: self-checking bench for nmea_sentence_parser (byte stream in, parse events out).
// Depends on nsp_pkg for event codes, characters, sizes and event_t; drives the DUT ports only.
`timescale 1ns / 1ps

module testbench;
  import nsp_pkg::*;

  // Pinned expectation travels with a byte until the byte is accepted.
  typedef struct packed {
    logic   pinned;
    logic   fires;
    event_t ev;
  } pin_t;

  // Directed row: {ch, reps, pinned, fires, event}; a pin applies to the last repeat only.
  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] reps;
    logic       pinned;
    logic       fires;
    event_t     ev;
  } script_row_t;

  localparam int NUM_ROWS = 31;
  localparam int RANDOM_ITEMS = 1140;
  localparam logic [7:0] CH_ZERO = "0";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam event_t NO_EVENT = '0;

  logic clk;
  logic rst = 1'b1;

  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;

  logic       event_valid;
  logic       event_stall = 1'b0;
  logic [2:0] event_kind;
  logic [7:0] byte_value;
  logic [6:0] position;
  logic [7:0] computed_checksum;
  logic [7:0] received_checksum;

  nmea_sentence_parser u_dut (
    .clk               (clk),
    .rst               (rst),
    .rx_valid          (rx_valid),
    .rx_stall          (rx_stall),
    .rx_byte           (rx_byte),
    .event_valid       (event_valid),
    .event_stall       (event_stall),
    .event_kind        (event_kind),
    .byte_value        (byte_value),
    .position          (position),
    .computed_checksum (computed_checksum),
    .received_checksum (received_checksum)
  );

  // Parser state as the bench sees it.
  logic [2:0] phase_q;
  logic [7:0] xor_sum;
  logic [6:0] byte_pos;
  logic [3:0] hex_high;

  pin_t        pin_q[$];           // one entry per byte handed to the driver
  event_t      pending_events[$];  // events still owed by the DUT
  script_row_t script [NUM_ROWS];
  int          items_sent = 0;
  bit          quiet = 1'b0;       // no idling on either side
  bit          failed = 1'b0;
  int          stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

  // Hex digit decode: fold lower case, then digits from '0', everything else from 'A'.
  // Only the low nibble survives, so any byte yields a value.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] u;
    logic [7:0] n;
    u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - 8'd32 : c;
    n = (u <= CH_NINE) ? u - CH_ZERO : u - CH_UPPER_A + 8'd10;
    return n[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return CH_ZERO + {4'd0, n};
    end
    return ($urandom_range(0, 1) ? CH_LOWER_A : CH_UPPER_A) + {4'd0, n} - 8'd10;
  endfunction

  // One accepted byte through the sentence state machine; fires when an event is owed.
  task automatic parse_rx_byte(input logic [7:0] d, output logic fires, output event_t ev);
    logic [6:0] at;
    logic [7:0] rx;
    at = byte_pos;
    fires = 1'b0;
    ev = NO_EVENT;
    case (phase_q)
      PH_CMD: begin
        fires = 1'b1;
        if (d == CH_STAR) begin
          // star ends the command without entering the checksum
          byte_pos = '0;
          phase_q = PH_HEX1;
          ev = {EV_CMD_END, d, at, xor_sum, 8'h00};
        end else begin
          xor_sum ^= d;
          if (d == CH_SPACE || d == CH_COMMA) begin
            byte_pos = '0;
            phase_q = PH_DATA;
            ev = {EV_CMD_END, d, at, xor_sum, 8'h00};
          end else if (int'(at) >= MAX_COMMAND_LEN) begin
            phase_q = PH_SEARCH;
            ev = {EV_OVERFLOW, d, at, xor_sum, 8'h00};
          end else begin
            byte_pos = at + 7'd1;
            ev = {EV_CMD_BYTE, d, at, xor_sum, 8'h00};
          end
        end
      end
      PH_DATA: begin
        if (d == CH_STAR) begin
          phase_q = PH_HEX1;
        end else if (d == CH_NEWLINE) begin
          fires = 1'b1;
          phase_q = PH_SEARCH;
          ev = {EV_NO_CK, d, at, xor_sum, 8'h00};
        end else begin
          fires = 1'b1;
          xor_sum ^= d;
          if (int'(at) + 1 >= MAX_DATA_LEN) begin
            phase_q = PH_SEARCH;
            ev = {EV_OVERFLOW, d, at, xor_sum, 8'h00};
          end else begin
            byte_pos = at + 7'd1;
            ev = {EV_DATA_BYTE, d, at, xor_sum, 8'h00};
          end
        end
      end
      PH_HEX1: begin
        hex_high = hex_value(d);
        phase_q = PH_HEX2;
      end
      PH_HEX2: begin
        rx = {hex_high, hex_value(d)};
        fires = 1'b1;
        phase_q = PH_SEARCH;
        ev = {(rx == xor_sum) ? EV_CK_OK : EV_CK_BAD, d, at, xor_sum, rx};
      end
      default: begin
        phase_q = PH_SEARCH;
        if (d == CH_DOLLAR) begin
          xor_sum = '0;
          byte_pos = '0;
          phase_q = PH_CMD;
        end
      end
    endcase
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // Monitor: both handshakes are sampled here with pre-edge values, prediction before
  // checking, so ordering within the time step never matters. Also drives event_stall.
  always @(posedge clk) begin
    pin_t   pin;
    logic   fires;
    event_t ev;
    event_t want;
    if (rst) begin
      phase_q  = PH_SEARCH;
      xor_sum  = '0;
      byte_pos = '0;
      hex_high = '0;
    end else begin
      if (rx_valid && !rx_stall) begin
        pin = pin_q.pop_front();
        parse_rx_byte(rx_byte, fires, ev);
        if (pin.pinned) begin
          fires = pin.fires;
          ev = pin.ev;
        end
        if (fires) begin
          pending_events.push_back(ev);
        end
      end
      if (event_valid && !event_stall) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual kind %0d value 0x%0h",
                   $time, event_kind, byte_value);
          failed = 1'b1;
        end else begin
          want = pending_events.pop_front();
          report_field("event_kind", int'(want.kind), int'(event_kind));
          report_field("byte_value", int'(want.value), int'(byte_value));
          report_field("position", int'(want.position), int'(position));
          report_field("computed_checksum", int'(want.computed), int'(computed_checksum));
          report_field("received_checksum", int'(want.received), int'(received_checksum));
        end
      end
    end
    // random stall bursts on the event side
    if (quiet) begin
      event_stall <= 1'b0;
    end else if (stall_left != 0) begin
      event_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = int'($urandom_range(0, 10));
      event_stall <= 1'b1;
    end else begin
      event_stall <= 1'b0;
    end
  end

  // Hand one byte to the DUT and hold it until the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic pinned = 1'b0,
                           input logic fires = 1'b0, input event_t ev = '0);
    pin_q.push_back({pinned, fires, ev});
    if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    items_sent++;
  endtask

  task automatic drain_events();
    rx_valid <= 1'b0;
    while (pin_q.size() != 0 || pending_events.size() != 0) @(posedge clk);
  endtask

  task automatic send_checksum(input logic [7:0] sum);
    if ($urandom_range(0, 4) == 0) begin
      // arbitrary bytes still decode to some nibble
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(hex_char(sum[7:4]));
      send_byte(hex_char(sum[3:0]));
    end
  endtask

  // One random sentence: mostly well formed with random content; some carry junk bytes,
  // overflow, a bad checksum, or no terminator at all.
  task automatic send_sentence();
    logic [7:0] sum;
    logic [7:0] c;
    int         noise;
    int         cmd_len;
    int         data_len;
    int         ending;
    bit         messy;
    messy = ($urandom_range(0, 9) == 0);
    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (int i = 0; i < noise; i++) begin
      c = 8'($urandom_range(0, 255));
      send_byte((c == CH_DOLLAR) ? 8'h00 : c);
    end
    send_byte(CH_DOLLAR);
    sum = '0;

    cmd_len = ($urandom_range(0, 11) == 0) ?
              $urandom_range(MAX_COMMAND_LEN + 1, MAX_COMMAND_LEN + 3) :
              $urandom_range(0, MAX_COMMAND_LEN);
    for (int i = 0; i < cmd_len; i++) begin
      c = messy ? 8'($urandom_range(0, 255)) : 8'($urandom_range("A", "Z"));
      if (c == CH_SPACE || c == CH_COMMA || c == CH_STAR) begin
        c = "Q";
      end
      send_byte(c);
      sum ^= c;
    end
    if (cmd_len > MAX_COMMAND_LEN) begin
      return;
    end

    case ($urandom_range(0, 4))
      0, 1:    c = CH_COMMA;
      2:       c = CH_SPACE;
      3:       c = CH_STAR;
      default: c = CH_COMMA;
    endcase
    send_byte(c);
    if (c == CH_STAR) begin
      send_checksum(sum);
      return;
    end
    sum ^= c;

    data_len = ($urandom_range(0, 24) == 0) ?
               $urandom_range(MAX_DATA_LEN - 8, MAX_DATA_LEN + 2) : $urandom_range(0, 20);
    for (int i = 0; i < data_len; i++) begin
      c = messy ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
      if (c == CH_STAR || c == CH_NEWLINE) begin
        c = "#";
      end
      send_byte(c);
      sum ^= c;
    end
    if (data_len >= MAX_DATA_LEN) begin
      return;
    end

    ending = $urandom_range(0, 9);
    if (ending <= 6) begin
      send_byte(CH_STAR);
      send_checksum(sum);
    end else if (ending <= 8) begin
      send_byte(CH_NEWLINE);
    end
    // otherwise the sentence is left open and the next bytes land in its data
  endtask

  initial begin
    int  random_start;
    bit  paused;
    // Directed script. Pinned rows carry an event readable straight off the
    // protocol; the others go through the predictor.
    script = '{
      {8'h00,      8'd1,   1'b1, 1'b0, NO_EVENT},  // search ignores the low extreme
      {8'hFF,      8'd1,   1'b1, 1'b0, NO_EVENT},  // and the high extreme
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {8'h47,      8'd1,   1'b1, 1'b1, {EV_CMD_BYTE, 8'h47, 7'd0, 8'h47, 8'h00}},
      {8'h50,      8'd1,   1'b0, 1'b0, NO_EVENT},
      {CH_COMMA,   8'd1,   1'b0, 1'b0, NO_EVENT},
      {8'h00,      8'd1,   1'b0, 1'b0, NO_EVENT},  // data byte extremes
      {8'hFF,      8'd1,   1'b0, 1'b0, NO_EVENT},
      {CH_DOLLAR,  8'd1,   1'b0, 1'b0, NO_EVENT},  // dollar as plain data
      {CH_STAR,    8'd1,   1'b1, 1'b0, NO_EVENT},  // star in data is silent
      {8'h61,      8'd1,   1'b1, 1'b0, NO_EVENT},  // lower-case first digit
      {8'h7A,      8'd1,   1'b0, 1'b0, NO_EVENT},  // non-hex second digit
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {CH_STAR,    8'd1,   1'b1, 1'b1, {EV_CMD_END, CH_STAR, 7'd0, 8'h00, 8'h00}},
      {8'h30,      8'd1,   1'b1, 1'b0, NO_EVENT},
      {8'h30,      8'd1,   1'b1, 1'b1, {EV_CK_OK, 8'h30, 7'd0, 8'h00, 8'h00}},
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {CH_SPACE,   8'd1,   1'b0, 1'b0, NO_EVENT},  // empty command, space delimiter
      {8'h78,      8'd1,   1'b0, 1'b0, NO_EVENT},
      {CH_NEWLINE, 8'd1,   1'b0, 1'b0, NO_EVENT},  // newline skips the check
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {8'h41,      8'd8,   1'b0, 1'b0, NO_EVENT},  // fill the command
      {8'h42,      8'd1,   1'b1, 1'b1, {EV_OVERFLOW, 8'h42, 7'd8, 8'h42, 8'h00}},
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {CH_COMMA,   8'd1,   1'b0, 1'b0, NO_EVENT},
      {8'h55,      8'd127, 1'b0, 1'b0, NO_EVENT},  // fill the data
      {8'h55,      8'd1,   1'b1, 1'b1, {EV_OVERFLOW, 8'h55, 7'd127, 8'h2C, 8'h00}},
      {CH_DOLLAR,  8'd1,   1'b1, 1'b0, NO_EVENT},
      {CH_STAR,    8'd1,   1'b0, 1'b0, NO_EVENT},
      {8'h66,      8'd1,   1'b1, 1'b0, NO_EVENT},
      {8'h46,      8'd1,   1'b1, 1'b1, {EV_CK_BAD, 8'h46, 7'd0, 8'h00, 8'hFF}}
    };
    paused = 1'b0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      for (int r = 0; r < int'(script[i].reps); r++) begin
        send_byte(script[i].ch, script[i].pinned && r == int'(script[i].reps) - 1,
                  script[i].fires, script[i].ev);
      end
    end

    // Random sentences; one full drain midway, and a clean stretch at the end.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (!paused && items_sent - random_start > RANDOM_ITEMS / 2) begin
        drain_events();
        paused = 1'b1;
      end
      quiet = (items_sent - random_start > RANDOM_ITEMS - 150);
      send_sentence();
    end

    drain_events();
    repeat (8) @(posedge clk);
    if (!failed && pending_events.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/nsp_pkg.sv
hdl/nsp_step.sv
hdl/nmea_sentence_parser.sv
hdl/nsp_checker.sv
dv/testbench.sv
